[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files of the RTL folder.
// No dependencies; IMDU_ASSERT expects clk and rst_n in scope, IMDU_ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define IMDU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IMDU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/imdu_pkg.sv]
// Shared types and constants of the integer multiply/divide unit.
// No dependencies; used by every module of the unit.
package imdu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_WIDTH - 1);

    typedef enum logic [2:0] {
        ACT_MUL  = 3'd0,
        ACT_DIVS = 3'd1,
        ACT_DIVU = 3'd2,
        ACT_REMS = 3'd3,
        ACT_REMU = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

endpackage

[rtl/core/integer_mul_div_unit.sv]
// An accepted input beat runs 32 iterations of the shared shift/add-subtract datapath,
// then the signed result is formed into the output register once that register is free.
// No new input beat is taken while the iterations run.
// The next input is taken while a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
module integer_mul_div_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] result
);

    imdu_pkg::cmd_t cmd;

    imdu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    imdu_datapath u_dp
    (
        .clk       (clk),
        .cmd       (cmd),
        .action    (s_axis_tuser),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .result    (m_axis_tdata)
    );

endmodule

[rtl/core/imdu_datapath.sv]
// Datapath of the multiply/divide unit: shift-add multiply, restoring divide.
// Depends on imdu_pkg; driven by commands from imdu_ctrl.
module imdu_datapath
(
    input  logic                             clk,
    input  imdu_pkg::cmd_t                   cmd,
    input  logic [2:0]                       action,
    input  logic [imdu_pkg::DATA_WIDTH-1:0]  operand_a,
    input  logic [imdu_pkg::DATA_WIDTH-1:0]  operand_b,
    output logic [imdu_pkg::DATA_WIDTH-1:0]  result
);

    localparam int W = imdu_pkg::DATA_WIDTH;

    imdu_pkg::action_t act_reg, act_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] acc_reg, acc_next;
    logic         neg_q_reg, neg_q_next;
    logic         neg_r_reg, neg_r_next;
    logic         bzero_reg, bzero_next;
    logic [W-1:0] result_reg, result_next;

    imdu_pkg::action_t in_act;
    logic         signed_op;
    logic         na, nb;
    logic [W:0]   shifted;
    logic [W:0]   diff;

    assign in_act    = imdu_pkg::action_t'(action);
    assign signed_op = (in_act == imdu_pkg::ACT_DIVS) || (in_act == imdu_pkg::ACT_REMS);
    assign na        = signed_op & operand_a[W-1];
    assign nb        = signed_op & operand_b[W-1];
    assign shifted   = {acc_reg, a_reg[W-1]};
    assign diff      = shifted - {1'b0, b_reg};

    always_comb
    begin
        act_next   = act_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        bzero_next = bzero_reg;
        if (cmd.load)
        begin
            act_next   = in_act;
            a_next     = na ? (~operand_a + 1'b1) : operand_a;
            b_next     = nb ? (~operand_b + 1'b1) : operand_b;
            acc_next   = '0;
            neg_q_next = na ^ nb;
            neg_r_next = na;
            bzero_next = (operand_b == '0);
        end
        else if (cmd.step)
        begin
            if (act_reg == imdu_pkg::ACT_MUL)
            begin
                acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
                a_next   = {a_reg[W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[W-1:1]};
            end
            else
            begin
                // A borrow out of the trial subtraction means the divisor did not fit.
                if (!diff[W])
                begin
                    acc_next = diff[W-1:0];
                    a_next   = {a_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = shifted[W-1:0];
                    a_next   = {a_reg[W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.finish)
        begin
            case (act_reg)
                imdu_pkg::ACT_MUL:  result_next = acc_reg;
                imdu_pkg::ACT_DIVS: result_next = bzero_reg ? '0 :
                                        (neg_q_reg ? (~a_reg + 1'b1) : a_reg);
                imdu_pkg::ACT_DIVU: result_next = bzero_reg ? '0 : a_reg;
                imdu_pkg::ACT_REMS: result_next = bzero_reg ? '0 :
                                        (neg_r_reg ? (~acc_reg + 1'b1) : acc_reg);
                imdu_pkg::ACT_REMU: result_next = bzero_reg ? '0 : acc_reg;
                default:            result_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
        bzero_reg  <= bzero_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[rtl/core/imdu_ctrl.sv]
// Controller of the multiply/divide unit: handshakes, iteration count, output valid.
// Depends on imdu_pkg; commands imdu_datapath.
module imdu_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output imdu_pkg::cmd_t cmd
);

    imdu_pkg::state_t           state_reg, state_next;
    logic [imdu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       valid_reg, valid_next;
    logic                       out_free;

    assign out_free = !valid_reg || out_ready;

    // Outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            imdu_pkg::ST_IDLE: in_ready = 1'b1;
            imdu_pkg::ST_RUN:  cmd.step = 1'b1;
            imdu_pkg::ST_FIN:
            begin
                cmd.finish = out_free;
                in_ready   = out_free;
            end
            default: in_ready = 1'b0;
        endcase
        cmd.load = in_valid && in_ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            imdu_pkg::ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = imdu_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            imdu_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == imdu_pkg::LAST_CNT)
                begin
                    state_next = imdu_pkg::ST_FIN;
                end
            end
            imdu_pkg::ST_FIN:
            begin
                // A new beat may start in the same cycle the result is handed over.
                if (cmd.load)
                begin
                    state_next = imdu_pkg::ST_RUN;
                    cnt_next   = '0;
                end
                else if (out_free)
                begin
                    state_next = imdu_pkg::ST_IDLE;
                end
            end
            default: state_next = imdu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.finish)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imdu_pkg::ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

endmodule

[rtl/core/imdu_checker.sv]
// Port-level checks of the multiply/divide unit, bound to the top level.
// Depends on assert_macros.svh and the ports of integer_mul_div_unit.
`include "assert_macros.svh"

module imdu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic s_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;

    `IMDU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    `IMDU_ASSERT(a_busy_after_beat, s_beat |=> !s_axis_tready, "input ready right after an accepted beat")
    `IMDU_ASSERT(a_busy_span, s_beat |-> ##32 !s_axis_tready, "input ready before the iterations ended")
    `IMDU_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind integer_mul_div_unit imdu_checker u_imdu_checker (.*);
